/* rtl/core/datagram_replay_filter_defines.svh */
// ---------------------------------------------------------------------------
// Datagram replay filter assertion macros
// Shared concurrent assertion macros; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef DATAGRAM_REPLAY_FILTER_DEFINES_SVH
`define DATAGRAM_REPLAY_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

`define DRF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("datagram replay filter: assertion failed");

`define DRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("datagram replay filter: assertion failed");

`else

`define DRF_ASSERT_SAME(label, clk, rst, ante, cons)

`define DRF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/drf_pkg.sv */
// ---------------------------------------------------------------------------
// Datagram replay filter package
// Types, codes and reset values shared by the filter modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package drf_pkg;

   localparam int WINDOW_SIZE_DEFAULT = 64;

   localparam int MAGIC_W   = 32;
   localparam int VERSION_W = 8;
   localparam int HDR_W     = 11;
   localparam int TAG_W     = 5;
   localparam int BYTES_W   = 12;
   localparam int PLEN_W    = 16;
   localparam int SEQ_W     = 32;
   localparam int TOTAL_W   = 17;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [MAGIC_W-1:0]   MAGIC_RESET   = '0;
   localparam logic [VERSION_W-1:0] VERSION_RESET = VERSION_W'(1);
   localparam logic [HDR_W-1:0]     HEADER_RESET  = HDR_W'(48);
   localparam logic [TAG_W-1:0]     TAG_RESET     = TAG_W'(16);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAGIC   = 2'd0,
      CSR_VERSION = 2'd1,
      CSR_HEADER  = 2'd2,
      CSR_TAG     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      VERDICT_OK     = 3'd0,
      VERDICT_SHORT  = 3'd1,
      VERDICT_BADHDR = 3'd2,
      VERDICT_LENGTH = 3'd3,
      VERDICT_AUTH   = 3'd4,
      VERDICT_OLD    = 3'd5,
      VERDICT_DUP    = 3'd6
   } verdict_type;

   typedef struct packed {
      logic [MAGIC_W-1:0]   magic_value;
      logic [VERSION_W-1:0] version_value;
      logic [HDR_W-1:0]     header_bytes;
      logic [TAG_W-1:0]     tag_bytes;
   } cfg_type;

   typedef struct packed {
      logic                 auth_ok;
      logic [SEQ_W-1:0]     seq_number;
      logic [PLEN_W-1:0]    payload_length;
      logic [VERSION_W-1:0] hdr_version;
      logic [MAGIC_W-1:0]   hdr_magic;
      logic [BYTES_W-1:0]   byte_count;
   } item_type;

endpackage

/* rtl/core/datagram_replay_filter.sv */
// ---------------------------------------------------------------------------
// Datagram replay filter
// Header checks and anti-replay window for received datagram summaries.
// ---------------------------------------------------------------------------
// Each transfer on the req_ channel carries one datagram summary. The block
// returns exactly one transfer on the rsp_ channel for it, holding an accept
// flag and a verdict code, in the same order as the requests.
// A request is captured in an input register; the checks and the window
// lookup run between that register and the result register, which drives
// rsp_tvalid. One request is taken every cycle while the receiver keeps
// up; the window state is updated as an item moves into the result
// register, so the next item already sees it.
// When the receiver stalls, the result register holds and the input register
// fills; req_tready then drops until rsp_tready returns.
// Reset clears both registers, the window (highest sequence zero, mask
// empty) and loads the register defaults. Registers on the csr_ port are
// written at any edge with csr_we high and should change only while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module datagram_replay_filter
   import drf_pkg::*;
#(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // byte_count, hdr_magic, hdr_version, payload_length, seq_number, auth_ok
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // accept, verdict
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        s1_valid_ff;
   logic        s1_valid_in;
   item_type    s1_item_ff;
   item_type    s1_item_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic        out_accept_ff;
   logic        out_accept_in;
   verdict_type out_verdict_ff;
   verdict_type out_verdict_in;

   logic        req_fire;
   logic        s1_move;
   verdict_type hdr_verdict;
   verdict_type win_verdict;
   verdict_type final_verdict;

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_fire   = req_tvalid && req_tready;

   drf_hdr_check u_hdr_check (
      .cfg     (cfg_ff),
      .item    (s1_item_ff),
      .verdict (hdr_verdict)
   );

   drf_window #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .commit     (s1_move),
      .pre_ok     (hdr_verdict == VERDICT_OK),
      .seq_number (s1_item_ff.seq_number),
      .verdict    (win_verdict)
   );

   assign final_verdict = (hdr_verdict != VERDICT_OK) ? hdr_verdict : win_verdict;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAGIC:   cfg_in.magic_value   = csr_wdata[MAGIC_W-1:0];
            CSR_VERSION: cfg_in.version_value = csr_wdata[VERSION_W-1:0];
            CSR_HEADER:  cfg_in.header_bytes  = csr_wdata[HDR_W-1:0];
            CSR_TAG:     cfg_in.tag_bytes     = csr_wdata[TAG_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_item_in     = s1_item_ff;
      out_valid_in   = out_valid_ff;
      out_accept_in  = out_accept_ff;
      out_verdict_in = out_verdict_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_item_in  = item_type'(req_tdata[$bits(item_type)-1:0]);
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (s1_move) begin
         out_valid_in   = 1'b1;
         out_accept_in  = (final_verdict == VERDICT_OK);
         out_verdict_in = final_verdict;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_value   <= MAGIC_RESET;
         cfg_ff.version_value <= VERSION_RESET;
         cfg_ff.header_bytes  <= HEADER_RESET;
         cfg_ff.tag_bytes     <= TAG_RESET;
         s1_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_item_ff     <= s1_item_in;
      out_accept_ff  <= out_accept_in;
      out_verdict_ff <= out_verdict_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 4)'(0), out_verdict_ff, out_accept_ff};

endmodule

/* rtl/core/drf_hdr_check.sv */
// ---------------------------------------------------------------------------
// Datagram replay filter header check
// Size, magic, version, length and authentication checks, first failure wins.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module drf_hdr_check
   import drf_pkg::*;
(
   input  cfg_type     cfg,
   input  item_type    item,
   output verdict_type verdict
);

   logic [BYTES_W-1:0] min_bytes;
   logic [TOTAL_W-1:0] total_bytes;

   assign min_bytes   = BYTES_W'(cfg.header_bytes) + BYTES_W'(cfg.tag_bytes);
   assign total_bytes = TOTAL_W'(cfg.header_bytes) + TOTAL_W'(item.payload_length)
                        + TOTAL_W'(cfg.tag_bytes);

   always_comb begin
      if (item.byte_count < min_bytes) begin
         verdict = VERDICT_SHORT;
      end else if (item.hdr_magic != cfg.magic_value ||
                   item.hdr_version != cfg.version_value) begin
         verdict = VERDICT_BADHDR;
      end else if (TOTAL_W'(item.byte_count) != total_bytes) begin
         verdict = VERDICT_LENGTH;
      end else if (!item.auth_ok) begin
         verdict = VERDICT_AUTH;
      end else begin
         verdict = VERDICT_OK;
      end
   end

endmodule

/* rtl/core/drf_window.sv */
// ---------------------------------------------------------------------------
// Datagram replay filter window
// Anti-replay sliding window: highest sequence and seen mask, at most one
// update per committed transfer, made only when the item is accepted.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "datagram_replay_filter_defines.svh"

module drf_window
   import drf_pkg::*;
#(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             commit,
   input  logic             pre_ok,
   input  logic [SEQ_W-1:0] seq_number,
   output verdict_type      verdict
);

   localparam int IDX_W = $clog2(WINDOW_SIZE);

   logic [SEQ_W-1:0]       highest_ff;
   logic [SEQ_W-1:0]       highest_in;
   logic [WINDOW_SIZE-1:0] seen_ff;
   logic [WINDOW_SIZE-1:0] seen_in;

   logic                   forward;
   logic [SEQ_W-1:0]       diff_fwd;
   logic [SEQ_W-1:0]       diff_back;
   logic                   in_window;
   logic [IDX_W-1:0]       back_idx;
   logic                   update;

   assign forward   = seq_number > highest_ff;
   assign diff_fwd  = seq_number - highest_ff;
   assign diff_back = highest_ff - seq_number;
   assign in_window = diff_back < SEQ_W'(WINDOW_SIZE);
   assign back_idx  = diff_back[IDX_W-1:0];

   always_comb begin
      if (forward) begin
         verdict = VERDICT_OK;
      end else if (!in_window) begin
         verdict = VERDICT_OLD;
      end else if (seen_ff[back_idx]) begin
         verdict = VERDICT_DUP;
      end else begin
         verdict = VERDICT_OK;
      end
   end

   assign update = commit && pre_ok && (verdict == VERDICT_OK);

   always_comb begin
      highest_in = highest_ff;
      seen_in    = seen_ff;
      if (update) begin
         if (forward) begin
            highest_in = seq_number;
            if (diff_fwd < SEQ_W'(WINDOW_SIZE)) begin
               seen_in = (seen_ff << diff_fwd[IDX_W-1:0]) | WINDOW_SIZE'(1);
            end else begin
               seen_in = WINDOW_SIZE'(1);
            end
         end else begin
            seen_in = seen_ff | (WINDOW_SIZE'(1) << back_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         highest_ff <= '0;
         seen_ff    <= '0;
      end else begin
         highest_ff <= highest_in;
         seen_ff    <= seen_in;
      end
   end

   `DRF_ASSERT_SAME(a_newest_marked, clock, reset, seen_ff != '0, seen_ff[0])
   `DRF_ASSERT_NEXT(a_forward_takes_max, clock, reset, update && forward,
      highest_ff == $past(seq_number))
   `DRF_ASSERT_NEXT(a_reject_holds_state, clock, reset, commit && !update,
      $stable(highest_ff) && $stable(seen_ff))

endmodule
